@@ rtl/sfc_pkg.sv @@
// shared types, constants and helper functions of the substring find and count block
package sfc_pkg;

    // sizes
    localparam int unsigned MAX_PATTERN = 8;
    localparam int unsigned MAX_TEXT    = 65536;
    localparam int unsigned PAT_IW      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int unsigned POS_W       = $clog2(MAX_TEXT + 1);
    localparam int unsigned LEN_W       = 4;
    localparam int unsigned IDX_W       = 16;
    localparam int unsigned CNT_W       = 17;
    localparam int unsigned COUNT_SAT   = 65536;
    localparam int unsigned CFG_IW      = 3;

    // ascii case folding
    localparam logic [7:0] FOLD_STEP = 8'd32;
    localparam logic [7:0] UPPER_LO  = 8'h41;
    localparam logic [7:0] UPPER_HI  = 8'h5A;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] REG_PATTERN_BYTES  = 3'd0;
    localparam logic [CFG_IW-1:0] REG_PATTERN_LENGTH = 3'd1;
    localparam logic [CFG_IW-1:0] REG_CASE_SENSITIVE = 3'd2;
    localparam logic [CFG_IW-1:0] REG_FIRST_FROM     = 3'd3;
    localparam logic [CFG_IW-1:0] REG_LAST_LIMIT     = 3'd4;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic             found_first;
        logic [IDX_W-1:0] first_index;
        logic             found_last;
        logic [IDX_W-1:0] last_index;
        logic [CNT_W-1:0] match_count;
        logic             too_long;
    } out_word_t;

    typedef struct packed {
        logic [8*MAX_PATTERN-1:0] pattern_bytes;
        logic [LEN_W-1:0]         pattern_length;
        logic                     case_sensitive;
        logic [IDX_W-1:0]         first_from;
        logic [IDX_W-1:0]         last_limit;
    } cfg_t;

    // fold A-Z to lower case
    function automatic logic [7:0] fold(input logic [7:0] c);
        if (c >= UPPER_LO && c <= UPPER_HI)
            return c + FOLD_STEP;
        return c;
    endfunction

    // pattern length clamped to the window depth
    function automatic logic [LEN_W-1:0] used_len(input logic [LEN_W-1:0] len);
        if (len > LEN_W'(MAX_PATTERN))
            return LEN_W'(MAX_PATTERN);
        return len;
    endfunction

endpackage

@@ rtl/substring_find_and_count_top.sv @@
// top level of the streaming substring find and count block
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  in_data   (text_byte, last_byte)
//  out      output     out_valid/out_stall out_data (first, last, count, too_long)
//  cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// one text byte is taken per cycle; a word passes an input register, then the
// window compare and tracking logic, and the final byte's result is then
// written into the output register.
// the only hold-up is a final byte that finds the output register still full.
// reset clears the window, the per-text state and the handshake flags.
// configuration writes are always ready and apply from the next byte on.
module substring_find_and_count_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  sfc_pkg::in_word_t          in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output sfc_pkg::out_word_t         out_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [sfc_pkg::CFG_IW-1:0] cfg_index,
    input  logic [63:0]                cfg_data
);

    sfc_pkg::cfg_t      cfg_reg, cfg_next;
    logic               s1_valid_reg, s1_valid_next;
    sfc_pkg::in_word_t  s1_word_reg;
    logic               out_valid_reg, out_valid_next;
    sfc_pkg::out_word_t out_word_reg;
    sfc_pkg::out_word_t result;

    logic in_take;
    logic out_take;
    logic out_free;
    logic go;
    logic live;
    logic hit;

    // handshake control
    assign in_take   = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || out_take;
    assign go        = s1_valid_reg && (!s1_word_reg.last_byte || out_free);
    assign in_stall  = s1_valid_reg && !go;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                sfc_pkg::REG_PATTERN_BYTES:  cfg_next.pattern_bytes  = cfg_data;
                sfc_pkg::REG_PATTERN_LENGTH:
                    cfg_next.pattern_length = cfg_data[sfc_pkg::LEN_W-1:0];
                sfc_pkg::REG_CASE_SENSITIVE: cfg_next.case_sensitive = cfg_data[0];
                sfc_pkg::REG_FIRST_FROM:
                    cfg_next.first_from = cfg_data[sfc_pkg::IDX_W-1:0];
                sfc_pkg::REG_LAST_LIMIT:
                    cfg_next.last_limit = cfg_data[sfc_pkg::IDX_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_bytes  <= '0;
            cfg_reg.pattern_length <= sfc_pkg::LEN_W'(1);
            cfg_reg.case_sensitive <= 1'b1;
            cfg_reg.first_from     <= '0;
            cfg_reg.last_limit     <= '1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // input register
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (go)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_word_reg <= in_data;
    end

    // window compare and tracking
    sfc_match u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift     (live),
        .clear     (go && s1_word_reg.last_byte),
        .text_byte (s1_word_reg.text_byte),
        .cfg       (cfg_reg),
        .hit       (hit)
    );

    sfc_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .last_byte (s1_word_reg.last_byte),
        .hit       (hit),
        .cfg       (cfg_reg),
        .live      (live),
        .result    (result)
    );

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (go && s1_word_reg.last_byte)
            out_valid_next = 1'b1;
        else if (out_take)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (go && s1_word_reg.last_byte)
            out_word_reg <= result;
    end

    // checks
    a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_word_reg.last_byte))
        else $error("result word without a final byte");

    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s1_word_reg.last_byte && out_valid_reg))
        else $error("input stalled with no blocked final byte");

    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_word_reg.match_count <= sfc_pkg::CNT_W'(sfc_pkg::COUNT_SAT)))
        else $error("match count above saturation");

    a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_word_reg.found_first) |-> (out_word_reg.first_index == '0))
        else $error("first index set without a match");

endmodule

@@ rtl/sfc_match.sv @@
// byte window shift register and parallel pattern compare
module sfc_match (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  logic                clear,
    input  logic [7:0]          text_byte,
    input  sfc_pkg::cfg_t       cfg,
    output logic                hit
);

    logic [sfc_pkg::MAX_PATTERN-1:0][7:0] window_reg;
    logic [sfc_pkg::MAX_PATTERN-1:0][7:0] window_next;
    logic [sfc_pkg::MAX_PATTERN-1:0][7:0] win_new;
    logic [sfc_pkg::LEN_W-1:0]            n;

    // window as it stands with the current byte shifted in
    always_comb
    begin
        win_new[0] = text_byte;
        for (int i = 1; i < int'(sfc_pkg::MAX_PATTERN); i++)
        begin
            win_new[i] = window_reg[i-1];
        end
    end

    // pattern byte j pairs with window entry n-1-j
    always_comb
    begin
        logic [sfc_pkg::LEN_W-1:0] d;
        logic [7:0]                p;
        logic [7:0]                w;
        n   = sfc_pkg::used_len(cfg.pattern_length);
        hit = (n != '0);
        for (int j = 0; j < int'(sfc_pkg::MAX_PATTERN); j++)
        begin
            d = n - sfc_pkg::LEN_W'(j) - sfc_pkg::LEN_W'(1);
            p = cfg.pattern_bytes[8*j +: 8];
            w = win_new[d[sfc_pkg::PAT_IW-1:0]];
            if (sfc_pkg::LEN_W'(j) < n)
            begin
                if (cfg.case_sensitive)
                begin
                    if (p != w)
                        hit = 1'b0;
                end
                else if (sfc_pkg::fold(p) != sfc_pkg::fold(w))
                begin
                    hit = 1'b0;
                end
            end
        end
    end

    // window update, cleared after the final byte
    always_comb
    begin
        window_next = window_reg;
        if (shift)
            window_next = win_new;
        if (clear)
            window_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= '0;
        else
            window_reg <= window_next;
    end

endmodule

@@ rtl/sfc_track.sv @@
// per-text position, first and last match, greedy count and overflow tracking
module sfc_track (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic                last_byte,
    input  logic                hit,
    input  sfc_pkg::cfg_t       cfg,
    output logic                live,
    output sfc_pkg::out_word_t  result
);

    logic [sfc_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [sfc_pkg::IDX_W-1:0] first_start_reg, first_start_next;
    logic                      first_seen_reg, first_seen_next;
    logic [sfc_pkg::IDX_W-1:0] last_start_reg, last_start_next;
    logic                      last_seen_reg, last_seen_next;
    logic [sfc_pkg::CNT_W-1:0] count_reg, count_next;
    logic [sfc_pkg::POS_W-1:0] free_reg, free_next;
    logic                      ovf_reg, ovf_next;

    logic [sfc_pkg::POS_W-1:0] n_ext;
    logic [sfc_pkg::POS_W-1:0] pos_inc;
    logic [sfc_pkg::POS_W-1:0] start;
    logic                      past_max;
    logic                      hit_ok;

    // start of the match ending at the current byte
    assign n_ext    = sfc_pkg::POS_W'(sfc_pkg::used_len(cfg.pattern_length));
    assign pos_inc  = pos_reg + sfc_pkg::POS_W'(1);
    assign start    = pos_inc - n_ext;
    assign past_max = (pos_reg >= sfc_pkg::POS_W'(sfc_pkg::MAX_TEXT));
    assign live     = go && !past_max;
    assign hit_ok   = live && hit && (pos_inc >= n_ext);

    // state update for one word
    always_comb
    begin
        pos_next         = pos_reg;
        first_start_next = first_start_reg;
        first_seen_next  = first_seen_reg;
        last_start_next  = last_start_reg;
        last_seen_next   = last_seen_reg;
        count_next       = count_reg;
        free_next        = free_reg;
        ovf_next         = ovf_reg;
        if (go && past_max)
            ovf_next = 1'b1;
        if (live)
            pos_next = pos_inc;
        if (hit_ok)
        begin
            if (!first_seen_reg && start >= sfc_pkg::POS_W'(cfg.first_from))
            begin
                first_seen_next  = 1'b1;
                first_start_next = start[sfc_pkg::IDX_W-1:0];
            end
            if (start <= sfc_pkg::POS_W'(cfg.last_limit))
            begin
                last_seen_next  = 1'b1;
                last_start_next = start[sfc_pkg::IDX_W-1:0];
            end
            if (start >= free_reg)
            begin
                if (count_reg < sfc_pkg::CNT_W'(sfc_pkg::COUNT_SAT))
                    count_next = count_reg + sfc_pkg::CNT_W'(1);
                free_next = start + n_ext;
            end
        end
    end

    // result as seen after this word
    always_comb
    begin
        result.found_first = first_seen_next;
        result.first_index = first_seen_next ? first_start_next : '0;
        result.found_last  = last_seen_next;
        result.last_index  = last_seen_next ? last_start_next : '0;
        result.match_count = count_next;
        result.too_long    = ovf_next;
    end

    // per-text registers, cleared after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            first_start_reg <= '0;
            first_seen_reg  <= 1'b0;
            last_start_reg  <= '0;
            last_seen_reg   <= 1'b0;
            count_reg       <= '0;
            free_reg        <= '0;
            ovf_reg         <= 1'b0;
        end
        else if (go && last_byte)
        begin
            pos_reg         <= '0;
            first_start_reg <= '0;
            first_seen_reg  <= 1'b0;
            last_start_reg  <= '0;
            last_seen_reg   <= 1'b0;
            count_reg       <= '0;
            free_reg        <= '0;
            ovf_reg         <= 1'b0;
        end
        else
        begin
            pos_reg         <= pos_next;
            first_start_reg <= first_start_next;
            first_seen_reg  <= first_seen_next;
            last_start_reg  <= last_start_next;
            last_seen_reg   <= last_seen_next;
            count_reg       <= count_next;
            free_reg        <= free_next;
            ovf_reg         <= ovf_next;
        end
    end

endmodule

@@ sim/tb_substring_find_and_count_top.sv @@
// self-checking testbench for the streaming substring find and count block
`timescale 1ns / 100ps

module tb_substring_find_and_count_top;
    import sfc_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned WORDS_PER_SET = 96;
    localparam int unsigned MAX_REPORTS   = 40;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    in_word_t           in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_word_t          out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_IW-1:0]  cfg_index = '0;
    logic [63:0]        cfg_data  = '0;

    // search settings as the block should hold them
    logic [63:0]        cfg_pattern;
    logic [LEN_W-1:0]   cfg_len;
    logic               cfg_exact;
    logic [IDX_W-1:0]   cfg_from;
    logic [IDX_W-1:0]   cfg_limit;

    // per-text scan state
    logic [7:0]         win_q [MAX_PATTERN];
    int unsigned        text_pos;
    int unsigned        first_start;
    int unsigned        last_start;
    int unsigned        nonover_cnt;
    int unsigned        free_start;
    bit                 first_hit;
    bit                 last_hit;
    bit                 over_len;

    // text summaries still to come out of the block
    out_word_t          due_q [$];
    out_word_t          want_w;

    int unsigned        send_idle_pct = 0;
    int unsigned        stall_pct     = 0;
    int unsigned        hold_reqs     = 0;
    int unsigned        hold_taken    = 0;
    int unsigned        hold_left     = 0;
    int unsigned        cycle_count   = 0;
    int unsigned        mismatch_count = 0;
    int unsigned        results_checked = 0;
    int unsigned        bytes_sent    = 0;
    int unsigned        texts_closed  = 0;
    int unsigned        cfg_writes    = 0;

    substring_find_and_count_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // receiver stall: long hold on request, random otherwise
    always @(posedge clk)
    begin
        if (hold_reqs != hold_taken)
        begin
            hold_taken <= hold_reqs;
            hold_left  <= HOLD_CYCLES;
            out_stall  <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("mismatch %s: got %0h want %0h at result %0d",
                     what, got, want, results_checked);
        mismatch_count++;
    endtask

    // compare each result word with the oldest pending summary
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_q.size() == 0)
            begin
                report_mismatch("result with nothing pending", 32'(out_data), 0);
            end
            else
            begin
                want_w = due_q.pop_front();
                if (out_data.found_first !== want_w.found_first)
                    report_mismatch("found_first", out_data.found_first,
                                    want_w.found_first);
                if (out_data.first_index !== want_w.first_index)
                    report_mismatch("first_index", out_data.first_index,
                                    want_w.first_index);
                if (out_data.found_last !== want_w.found_last)
                    report_mismatch("found_last", out_data.found_last,
                                    want_w.found_last);
                if (out_data.last_index !== want_w.last_index)
                    report_mismatch("last_index", out_data.last_index,
                                    want_w.last_index);
                if (out_data.match_count !== want_w.match_count)
                    report_mismatch("match_count", out_data.match_count,
                                    want_w.match_count);
                if (out_data.too_long !== want_w.too_long)
                    report_mismatch("too_long", out_data.too_long, want_w.too_long);
                results_checked++;
            end
        end
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles, %0d summaries pending",
                 cycle_count, due_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // A-Z to lower case, everything else unchanged
    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        if (c >= UPPER_LO && c <= UPPER_HI)
            return c + FOLD_STEP;
        return c;
    endfunction

    function automatic bit same_char(input logic [7:0] a, input logic [7:0] b);
        if (cfg_exact)
            return a == b;
        return lower_ascii(a) == lower_ascii(b);
    endfunction

    // oldest window byte lines up with pattern byte 0
    function automatic bit window_hit(input int unsigned n);
        for (int j = 0; j < n; j++)
            if (!same_char(win_q[n - 1 - j], cfg_pattern[8*j +: 8]))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic int unsigned active_len();
        return (cfg_len > MAX_PATTERN) ? MAX_PATTERN : int'(cfg_len);
    endfunction

    function automatic void clear_scan();
        foreach (win_q[i])
            win_q[i] = 8'h00;
        text_pos    = 0;
        first_start = 0;
        last_start  = 0;
        nonover_cnt = 0;
        free_start  = 0;
        first_hit   = 1'b0;
        last_hit    = 1'b0;
        over_len    = 1'b0;
    endfunction

    // advance the scan by one accepted byte; a final byte closes the text
    task automatic scan_byte(input logic [7:0] b, input bit is_last);
        int unsigned n;
        int unsigned s;
        out_word_t   w;
        if (text_pos >= MAX_TEXT)
        begin
            over_len = 1'b1;
        end
        else
        begin
            for (int i = MAX_PATTERN - 1; i > 0; i--)
                win_q[i] = win_q[i - 1];
            win_q[0] = b;
            n = active_len();
            if (n != 0 && text_pos + 1 >= n && window_hit(n))
            begin
                s = text_pos + 1 - n;
                if (!first_hit && s >= cfg_from)
                begin
                    first_hit   = 1'b1;
                    first_start = s & 32'hFFFF;
                end
                if (s <= cfg_limit)
                begin
                    last_hit   = 1'b1;
                    last_start = s & 32'hFFFF;
                end
                // greedy non-overlapping count
                if (s >= free_start)
                begin
                    if (nonover_cnt < COUNT_SAT)
                        nonover_cnt++;
                    free_start = s + n;
                end
            end
            text_pos++;
        end
        if (is_last)
        begin
            w.found_first = first_hit;
            w.first_index = first_hit ? first_start[IDX_W-1:0] : '0;
            w.found_last  = last_hit;
            w.last_index  = last_hit ? last_start[IDX_W-1:0] : '0;
            w.match_count = nonover_cnt[CNT_W-1:0];
            w.too_long    = over_len;
            due_q.push_back(w);
            texts_closed++;
            clear_scan();
        end
    endtask

    function automatic void apply_reg(input logic [CFG_IW-1:0] idx, input logic [63:0] data);
        case (idx)
            REG_PATTERN_BYTES:  cfg_pattern = data;
            REG_PATTERN_LENGTH: cfg_len     = data[LEN_W-1:0];
            REG_CASE_SENSITIVE: cfg_exact   = data[0];
            REG_FIRST_FROM:     cfg_from    = data[IDX_W-1:0];
            REG_LAST_LIMIT:     cfg_limit   = data[IDX_W-1:0];
            default: ;
        endcase
    endfunction

    // one text word, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input bit is_last);
        in_word_t w;
        w.text_byte = b;
        w.last_byte = is_last;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
        scan_byte(b, is_last);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, data);
        cfg_writes++;
    endtask

    // wait for every summary, then let the pipeline empty
    task automatic wait_idle();
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (due_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic load_search(input logic [63:0] pat, input logic [63:0] len_raw,
                               input logic [63:0] exact_raw, input logic [63:0] from_raw,
                               input logic [63:0] limit_raw);
        wait_idle();
        write_reg(REG_PATTERN_BYTES, pat);
        write_reg(REG_PATTERN_LENGTH, len_raw);
        write_reg(REG_CASE_SENSITIVE, exact_raw);
        write_reg(REG_FIRST_FROM, from_raw);
        write_reg(REG_LAST_LIMIT, limit_raw);
        cfg_valid <= 1'b0;
    endtask

    function automatic void set_idling(input int unsigned send_pct, input int unsigned rx_pct);
        send_idle_pct = send_pct;
        stall_pct     = rx_pct;
    endfunction

    // letters, fold boundaries and the byte extremes
    function automatic logic [7:0] pick_symbol();
        case ($urandom_range(11))
            0, 1:    return 8'h61;   // a
            2, 3:    return 8'h42;   // B
            4:       return 8'h63;   // c
            5:       return 8'h5A;   // Z
            6:       return 8'h40;   // just below A
            7:       return 8'h5B;   // just above Z
            8:       return 8'h00;
            9:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // flip the case of some letters
    function automatic logic [7:0] vary_case(input logic [7:0] c);
        logic [7:0] lc;
        lc = c | 8'h20;
        if (lc >= 8'h61 && lc <= 8'h7A && $urandom_range(99) < 30)
            return c ^ 8'h20;
        return c;
    endfunction

    task automatic load_random_search();
        logic [63:0] pat;
        logic [63:0] junk;
        logic [63:0] len_raw;
        logic [63:0] from_raw;
        logic [63:0] limit_raw;
        int unsigned r;
        for (int j = 0; j < MAX_PATTERN; j++)
            pat[8*j +: 8] = pick_symbol();
        junk    = {$urandom, $urandom};
        len_raw = junk;
        r = $urandom_range(99);
        if (r < 8)
            len_raw[LEN_W-1:0] = '0;
        else if (r < 16)
            len_raw[LEN_W-1:0] = LEN_W'($urandom_range(15, MAX_PATTERN + 1));
        else if (r < 30)
            len_raw[LEN_W-1:0] = LEN_W'(MAX_PATTERN);
        else
            len_raw[LEN_W-1:0] = LEN_W'($urandom_range(4, 1));
        from_raw = {$urandom, $urandom};
        r = $urandom_range(99);
        if (r < 50)
            from_raw[IDX_W-1:0] = '0;
        else if (r < 65)
            from_raw[IDX_W-1:0] = '1;
        else
            from_raw[IDX_W-1:0] = IDX_W'($urandom_range(15));
        limit_raw = {$urandom, $urandom};
        r = $urandom_range(99);
        if (r < 50)
            limit_raw[IDX_W-1:0] = '1;
        else if (r < 60)
            limit_raw[IDX_W-1:0] = '0;
        else
            limit_raw[IDX_W-1:0] = IDX_W'($urandom_range(15));
        load_search(pat, len_raw, {$urandom, $urandom}, from_raw, limit_raw);
    endtask

    // text mostly built from pattern copies, with fragments and noise between
    task automatic send_random_text(input int unsigned len);
        logic [7:0]  txt [$];
        int unsigned n;
        int unsigned r;
        n = active_len();
        while (txt.size() < len)
        begin
            r = $urandom_range(99);
            if (r < 55 && n != 0)
                for (int j = 0; j < n; j++)
                    txt.push_back(vary_case(cfg_pattern[8*j +: 8]));
            else if (r < 80)
                txt.push_back(vary_case(cfg_pattern[8*$urandom_range(n == 0 ? 0 : n - 1) +: 8]));
            else
                txt.push_back(8'($urandom_range(255)));
        end
        for (int k = 0; k < len; k++)
            send_byte(txt[k], k == len - 1);
    endtask

    function automatic int unsigned random_text_len();
        if ($urandom_range(99) < 10)
            return $urandom_range(60, 30);
        return $urandom_range(20, 1);
    endfunction

    // reset values: zero pattern byte, length one, exact compare
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    // folding, overlap, limits, zero and oversized lengths, short text
    task automatic test_match_rules();
        load_search(64'h4261, 4'd2, 1'b0, 16'd0, 16'hFFFF);     // "aB" folded
        send_byte(8'h78, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h42, 1'b1);
        send_byte(8'h61, 1'b1);                                  // shorter than pattern
        load_search(64'h5B40, 4'd2, 1'b0, 16'd0, 16'hFFFF);     // "@[" must not fold
        send_byte(8'h60, 1'b0);
        send_byte(8'h7B, 1'b0);
        send_byte(8'h40, 1'b0);
        send_byte(8'h5B, 1'b1);
        load_search(64'h6161, 4'd2, 1'b1, 16'd1, 16'd2);        // overlapping "aa"
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h41, 1'b1);
        // writes to unused register indexes change nothing
        wait_idle();
        for (int k = int'(REG_LAST_LIMIT) + 1; k < (1 << CFG_IW); k++)
            write_reg(CFG_IW'(k), {$urandom, $urandom});
        load_search(64'h6161, 4'd0, 1'b1, 16'd0, 16'hFFFF);    // zero length
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b1);
        load_search('1, 4'd15, 1'b1, 16'd0, 16'hFFFF);          // clamped to eight
        for (int k = 0; k < 9; k++)
            send_byte(8'hFF, k == 8);
    endtask

    // text past the maximum length: overflow, saturated count, top index
    task automatic test_long_text();
        set_idling(0, 0);
        load_search(64'h5A, 4'd1, 1'b0, 16'hFFFF, 16'hFFFF);
        for (int k = 0; k < MAX_TEXT + 3; k++)
            send_byte($urandom_range(1) ? 8'h5A : 8'h7A, k == MAX_TEXT + 2);
    endtask

    task automatic test_random_texts();
        int unsigned sent;
        int unsigned len;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       set_idling(0, 0);
                1:       set_idling(54, 0);
                2:       set_idling(0, 54);
                default: set_idling(32, 32);
            endcase
            for (int c = 0; c < 3; c++)
            begin
                load_random_search();
                sent = 0;
                while (sent < WORDS_PER_SET)
                begin
                    len = random_text_len();
                    send_random_text(len);
                    sent += len;
                end
            end
        end
    endtask

    // long receiver hold fills the block, then a sender pause until drained
    task automatic test_backpressure();
        set_idling(0, 0);
        load_random_search();
        hold_reqs <= hold_reqs + 1;
        for (int k = 0; k < 40; k++)
            send_random_text($urandom_range(2, 1));
        in_valid <= 1'b0;
        while (due_q.size() != 0)
            @(posedge clk);
        set_idling(32, 32);
        for (int k = 0; k < 20; k++)
            send_random_text($urandom_range(2, 1));
    endtask

    initial
    begin
        cfg_pattern = '0;
        cfg_len     = LEN_W'(1);
        cfg_exact   = 1'b1;
        cfg_from    = '0;
        cfg_limit   = '1;
        clear_scan();
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_match_rules();
        test_long_text();
        test_random_texts();
        test_backpressure();
        wait_idle();

        $display("sent %0d text bytes in %0d texts, %0d register writes, %0d results checked",
                 bytes_sent, texts_closed, cfg_writes, results_checked);
        $display("covered folding, limits, clamped lengths, overflow, idle mixes, long hold");
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
